FILE: rtl/core/pwa_pkg.sv
`default_nettype none
package pwa_pkg;

	// Request opcodes on the input channel.
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_DATA  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_PAGING   = 1'b0;
	localparam logic CFG_DIR_BASE = 1'b1;

	// Result queue geometry.
	localparam int RQ_DEPTH = 8;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);
	localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_RD  = 2'd0,
		KIND_WR  = 2'd1,
		KIND_CMP = 2'd2,
		KIND_FLT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_DIR   = 3'd1,
		PH_TBL   = 3'd2,
		PH_DATA  = 3'd3,
		PH_DRAIN = 3'd4
	} phase_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] virt_addr;
		logic [2:0]  access_size;
		logic [31:0] write_data;
		logic [31:0] mem_data;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] phys_addr;
		logic [2:0]  mem_size;
		logic [31:0] result_data;
		logic        last;
	} res_t;

	// Up to two results produced by one item.
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

	// Request context used while translating one access unit.
	typedef struct packed {
		logic [31:0] cur;
		logic [2:0]  size;
		logic        split;
		logic        write;
		logic [31:0] wdata;
	} ctx_t;

	typedef struct packed {
		res_t       res;
		phase_t     nphase;
		logic [2:0] nbyte;
		logic       cont;
	} act_t;

	// Starts an access unit (start set) or issues its final physical access at pa.
	function automatic act_t unit_act(input logic start, input logic paging,
			input logic [19:0] dbf, input ctx_t c, input logic [31:0] pa,
			input logic [2:0] b);
		act_t        a;
		logic [31:0] va;
		logic [31:0] wsh;
		logic        lst;
		logic [2:0]  us;
		va  = c.cur + {29'd0, b};
		us  = c.split ? 3'd1 : c.size;
		lst = !c.split || (({1'b0, b} + 4'd1) >= {1'b0, c.size});
		wsh = c.wdata >> {b[1:0], 3'b000};
		a.cont              = 1'b0;
		a.nbyte             = b;
		a.nphase            = PH_IDLE;
		a.res.kind          = KIND_RD;
		a.res.phys_addr     = start ? va : pa;
		a.res.mem_size      = us;
		a.res.result_data   = 32'd0;
		a.res.last          = 1'b0;
		if (start && paging) begin
			a.res.phys_addr = {dbf, va[31:22], 2'b00};
			a.res.mem_size  = 3'd4;
			a.nphase        = PH_DIR;
		end else if (c.write) begin
			a.res.kind        = KIND_WR;
			a.res.result_data = c.split ? {24'd0, wsh[7:0]} : c.wdata;
			a.res.last        = lst;
			if (!lst) begin
				a.cont  = 1'b1;
				a.nbyte = b + 3'd1;
			end
		end else begin
			a.nphase = PH_DATA;
		end
		return a;
	endfunction

	function automatic logic [31:0] size_mask(input logic [2:0] size);
		logic [31:0] m;
		case (size)
			3'd1:    m = 32'h0000_00FF;
			3'd2:    m = 32'h0000_FFFF;
			3'd3:    m = 32'h00FF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pwa_req_if.sv
`default_nettype none
interface pwa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] virt_addr;
	logic [2:0]  access_size;
	logic [31:0] write_data;
	logic [31:0] mem_data;

	modport source (output valid, output opcode, output virt_addr, output access_size,
		output write_data, output mem_data, input ready);
	modport sink (input valid, input opcode, input virt_addr, input access_size,
		input write_data, input mem_data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pwa_rsp_if.sv
`default_nettype none
interface pwa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] phys_addr;
	logic [2:0]  mem_size;
	logic [31:0] result_data;
	logic        last;

	modport source (output valid, output kind, output phys_addr, output mem_size,
		output result_data, output last, input ready);
	modport sink (input valid, input kind, input phys_addr, input mem_size,
		input result_data, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pwa_walk.sv
`default_nettype none
module pwa_walk import pwa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_v,
	input  wire item_t       item,
	input  wire logic        paging,
	input  wire logic [19:0] dbf,
	output push_t            push
);

	phase_t      phase_q, phase_n;
	logic [31:0] cur_q, cur_n;
	logic [2:0]  byte_q, byte_n;
	logic [2:0]  size_q, size_n;
	logic        write_q, write_n;
	logic        split_q, split_n;
	logic [31:0] wdata_q, wdata_n;
	logic [31:0] asm_q, asm_n;

	ctx_t        ctx;
	logic [2:0]  sz;
	logic [31:0] end_va;
	logic [31:0] va_u;
	logic [2:0]  us_u;
	logic        last_u;
	logic        use1;
	logic        start1;
	logic [31:0] pa1;
	logic [2:0]  b1;
	act_t        act1;
	act_t        act2;
	logic        is_req;
	logic        is_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cur_q   <= '0;
			byte_q  <= '0;
			size_q  <= '0;
			write_q <= 1'b0;
			split_q <= 1'b0;
			wdata_q <= '0;
			asm_q   <= '0;
		end else begin
			phase_q <= phase_n;
			cur_q   <= cur_n;
			byte_q  <= byte_n;
			size_q  <= size_n;
			write_q <= write_n;
			split_q <= split_n;
			wdata_q <= wdata_n;
			asm_q   <= asm_n;
		end
	end

	always_comb begin
		is_req  = item_v && (item.opcode == OP_READ || item.opcode == OP_WRITE);
		is_data = item_v && (item.opcode == OP_DATA);

		// Out-of-range sizes are clamped to the nearest legal one.
		sz = item.access_size;
		if (sz == 3'd0) begin
			sz = 3'd1;
		end else if (sz inside {[3'd5:3'd7]}) begin
			sz = 3'd4;
		end
		end_va = item.virt_addr + {29'd0, sz} - 32'd1;

		if (phase_q == PH_IDLE) begin
			ctx.cur   = item.virt_addr;
			ctx.size  = sz;
			ctx.split = item.virt_addr[31:12] != end_va[31:12];
			ctx.write = item.opcode == OP_WRITE;
			ctx.wdata = item.write_data;
		end else begin
			ctx.cur   = cur_q;
			ctx.size  = size_q;
			ctx.split = split_q;
			ctx.write = write_q;
			ctx.wdata = wdata_q;
		end

		va_u   = cur_q + {29'd0, byte_q};
		us_u   = split_q ? 3'd1 : size_q;
		last_u = !split_q || (({1'b0, byte_q} + 4'd1) >= {1'b0, size_q});

		phase_n = phase_q;
		cur_n   = cur_q;
		byte_n  = byte_q;
		size_n  = size_q;
		write_n = write_q;
		split_n = split_q;
		wdata_n = wdata_q;
		asm_n   = asm_q;
		use1    = 1'b0;
		start1  = 1'b1;
		pa1     = {item.mem_data[31:12], va_u[11:0]};
		b1      = byte_q;
		push    = '0;

		case (phase_q)
			PH_IDLE: begin
				if (is_req) begin
					cur_n   = ctx.cur;
					size_n  = ctx.size;
					split_n = ctx.split;
					write_n = ctx.write;
					wdata_n = ctx.wdata;
					byte_n  = 3'd0;
					asm_n   = 32'd0;
					use1    = 1'b1;
					b1      = 3'd0;
				end
			end
			PH_DIR: begin
				if (is_data) begin
					if (!item.mem_data[0]) begin
						push.v0 = 1'b1;
						push.r0 = '{KIND_FLT, va_u, us_u, 32'd0, 1'b1};
						phase_n = PH_IDLE;
					end else begin
						push.v0 = 1'b1;
						push.r0 = '{KIND_RD, {item.mem_data[31:12], va_u[21:12], 2'b00},
							3'd4, 32'd0, 1'b0};
						phase_n = PH_TBL;
					end
				end
			end
			PH_TBL: begin
				if (is_data) begin
					if (!item.mem_data[0]) begin
						push.v0 = 1'b1;
						push.r0 = '{KIND_FLT, va_u, us_u, 32'd0, 1'b1};
						phase_n = PH_IDLE;
					end else begin
						use1   = 1'b1;
						start1 = 1'b0;
					end
				end
			end
			PH_DATA: begin
				if (is_data) begin
					if (split_q) begin
						asm_n = asm_q | ({24'd0, item.mem_data[7:0]} << {byte_q[1:0], 3'b000});
					end else begin
						asm_n = item.mem_data & size_mask(size_q);
					end
					if (last_u) begin
						push.v0 = 1'b1;
						push.r0 = '{KIND_CMP, 32'd0, size_q, asm_n, 1'b1};
						phase_n = PH_IDLE;
					end else begin
						use1 = 1'b1;
						b1   = byte_q + 3'd1;
					end
				end
			end
			PH_DRAIN: begin
				if (is_data) begin
					use1 = 1'b1;
				end
			end
			default: begin
				if (is_data) begin
					phase_n = PH_IDLE;
				end
			end
		endcase

		act1 = unit_act(start1, paging, dbf, ctx, pa1, b1);
		act2 = unit_act(1'b1, paging, dbf, ctx, 32'd0, act1.nbyte);

		if (use1) begin
			push.v0 = 1'b1;
			push.r0 = act1.res;
			phase_n = act1.nphase;
			byte_n  = act1.nbyte;
			if (act1.cont) begin
				push.v1 = 1'b1;
				push.r1 = act2.res;
				phase_n = act2.nphase;
				byte_n  = act2.nbyte;
				if (act2.cont) begin
					phase_n = PH_DRAIN;
				end
			end
		end
	end

	a_fault_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(push.v0 && push.r0.kind == KIND_FLT) |=> phase_q == PH_IDLE)
		else $error("walk did not return to idle after a page fault");

	a_second_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> (push.r0.kind == KIND_WR && !push.r0.last))
		else $error("second result not preceded by a non-final write");

	a_drain_split_write: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DRAIN |-> (write_q && split_q))
		else $error("drain phase outside a split write");

endmodule
`default_nettype wire

FILE: rtl/core/pwa_rq.sv
`default_nettype none
module pwa_rq import pwa_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire push_t            push,
	input  wire logic             pop,
	output logic                  head_v,
	output res_t                  head,
	output logic [RQ_CW-1:0]      count
);

	res_t             mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_q;
	logic [RQ_AW-1:0] rd_q;
	logic [RQ_CW-1:0] cnt_q;
	logic [RQ_AW-1:0] wr_p1;

	assign wr_p1  = wr_q + RQ_AW'(1);
	assign head_v = cnt_q != '0;
	assign head   = mem_q[rd_q];
	assign count  = cnt_q;

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RQ_AW'(push.v0) + RQ_AW'(push.v1);
			rd_q  <= rd_q + RQ_AW'(pop);
			cnt_q <= cnt_q + RQ_CW'(push.v0) + RQ_CW'(push.v1) - RQ_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RQ_CW'(RQ_DEPTH))
		else $error("result queue overflow");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0)
		else $error("second push slot used without the first");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cnt_q == RQ_CW'(1) && !push.v0) |=> !head_v)
		else $error("queue not empty after draining its last item");

endmodule
`default_nettype wire

FILE: rtl/core/two_level_page_walk_access_unit.sv
// An item passes the input stage register, the walk and the result queue to rsp.
// Throughput: one input item per cycle while req.ready is high; rsp moves one result
// item per cycle while rsp.ready is high, so items that cause two results drain
// through the eight-entry result queue at that rate.
// Reset (arst_n low, asynchronous): walk idle, translation off, directory base zero,
// result queue empty.
`default_nettype none
module two_level_page_walk_access_unit import pwa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [19:0] cfg_data,
	pwa_req_if.sink          req,
	pwa_rsp_if.source        rsp
);

	// Configuration registers: paging enable and page directory base frame.
	logic        paging_q;
	logic [19:0] dbf_q;

	// Input stage register. Each registered item is consumed by the walk logic in
	// the following cycle, so the stage never stalls on its own.
	logic  v_s1;
	item_t item_s1;

	push_t            push;
	logic             pop;
	logic             head_v;
	res_t             head;
	logic [RQ_CW-1:0] rq_count;
	logic [RQ_CW:0]   reserved;
	logic             accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_q <= 1'b0;
			dbf_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAGING:   paging_q <= cfg_data[0];
				CFG_DIR_BASE: dbf_q    <= cfg_data;
				default:      paging_q <= paging_q;
			endcase
		end
	end

	// Flow control: every item may cause up to two results. An item is taken only
	// when the queue can hold two results for it on top of two for the item that
	// sits in the input stage, so nothing is ever dropped.
	always_comb begin
		reserved = {1'b0, rq_count} + (v_s1 ? (RQ_CW+1)'(2) : '0);
	end
	assign req.ready = reserved <= (RQ_CW+1)'(RQ_DEPTH - 2);
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode      <= req.opcode;
			item_s1.virt_addr   <= req.virt_addr;
			item_s1.access_size <= req.access_size;
			item_s1.write_data  <= req.write_data;
			item_s1.mem_data    <= req.mem_data;
		end
	end

	// The walk holds the request context and phase (directory read, table read,
	// data wait, split-write drain) and turns one item into zero, one or two results.
	pwa_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.item_v (v_s1),
		.item   (item_s1),
		.paging (paging_q),
		.dbf    (dbf_q),
		.push   (push)
	);

	// The result queue decouples the output side: input items keep flowing while
	// earlier results wait for rsp.ready, as long as the queue has room.
	assign pop = head_v && rsp.ready;

	pwa_rq u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head_v (head_v),
		.head   (head),
		.count  (rq_count)
	);

	assign rsp.valid       = head_v;
	assign rsp.kind        = head.kind;
	assign rsp.phys_addr   = head.phys_addr;
	assign rsp.mem_size    = head.mem_size;
	assign rsp.result_data = head.result_data;
	assign rsp.last        = head.last;

endmodule
`default_nettype wire

FILE: dv/tb_two_level_page_walk_access_unit.sv
`default_nettype none
module tb_two_level_page_walk_access_unit;
	import pwa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The package has no name for the fourth opcode; the block ignores it in every phase.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Cycles without any handshake on either channel before the run is declared hung.
	localparam int HANG_LIMIT = 2000;

	// Cycles to let pass once nothing is expected any more. The block holds an item in its
	// input stage and its results in the result queue, so this covers an item that produced nothing.
	localparam int SETTLE_CYCLES = 8;

	// Items of mem data with the present bit set that finish any walk left open.
	// The longest walk is a split paged read of four bytes: twelve data items.
	localparam int FLUSH_ITEMS = 16;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [19:0] cfg_data;

	pwa_req_if req ();
	pwa_rsp_if rsp ();

	two_level_page_walk_access_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Walk predictor. It keeps its own copy of the registers and of the
	// walk state and turns every accepted item into the results the
	// block must send, in order. At most two results come from one item;
	// anything beyond that would be dropped here.
	// ------------------------------------------------------------------
	logic        paging_on  = 1'b0;
	logic [19:0] dir_frame  = 20'd0;
	phase_t      walk_phase = PH_IDLE;
	logic [31:0] walk_va    = 32'd0;
	logic [2:0]  walk_byte  = 3'd0;
	logic [2:0]  walk_size  = 3'd0;
	logic        walk_wr    = 1'b0;
	logic        walk_split = 1'b0;
	logic [31:0] walk_wdata = 32'd0;
	logic [31:0] walk_rdata = 32'd0;
	int          posted;

	// Results still owed by the block, oldest first.
	res_t awaited_results[$];

	int mismatches = 0;

	// Virtual address, size and finality of the piece being translated. A split
	// access is walked one byte at a time; a whole access is a single piece.
	function automatic logic [31:0] piece_va();
		return walk_va + {29'd0, walk_byte};
	endfunction

	function automatic logic [2:0] piece_size();
		return walk_split ? 3'd1 : walk_size;
	endfunction

	function automatic logic piece_is_last();
		return !walk_split || (({1'b0, walk_byte} + 4'd1) >= {1'b0, walk_size});
	endfunction

	task automatic post_result(input kind_t k, input logic [31:0] addr, input logic [2:0] size,
			input logic [31:0] data, input logic lst);
		res_t r;
		if (posted < 2) begin
			r.kind        = k;
			r.phys_addr   = addr;
			r.mem_size    = size;
			r.result_data = data;
			r.last        = lst;
			awaited_results.push_back(r);
			posted++;
		end
	endtask

	// Issues the physical access of the current piece. For a write that has
	// more bytes to go, more is set when there is room to start the next piece
	// within this item; otherwise the walk parks until the next data item.
	task automatic finish_piece(input logic [31:0] pa, output logic more);
		logic [31:0] d;
		logic        lst;
		more = 1'b0;
		if (walk_wr) begin
			d   = walk_split ? ((walk_wdata >> {walk_byte[1:0], 3'b000}) & 32'h0000_00FF)
					: walk_wdata;
			lst = piece_is_last();
			post_result(KIND_WR, pa, piece_size(), d, lst);
			if (lst) begin
				walk_phase = PH_IDLE;
			end else begin
				walk_byte++;
				if (posted < 2)
					more = 1'b1;
				else
					walk_phase = PH_DRAIN;
			end
		end else begin
			post_result(KIND_RD, pa, piece_size(), 32'd0, 1'b0);
			walk_phase = PH_DATA;
		end
	endtask

	task automatic start_piece();
		logic        more;
		logic [31:0] va;
		more = 1'b1;
		while (more) begin
			more = 1'b0;
			va   = piece_va();
			if (paging_on) begin
				post_result(KIND_RD, {dir_frame, va[31:22], 2'b00}, 3'd4, 32'd0, 1'b0);
				walk_phase = PH_DIR;
			end else begin
				finish_piece(va, more);
			end
		end
	endtask

	task automatic raise_fault();
		post_result(KIND_FLT, piece_va(), piece_size(), 32'd0, 1'b1);
		walk_phase = PH_IDLE;
	endtask

	task automatic translate_item(input item_t it);
		logic [2:0]  sz;
		logic [31:0] end_va;
		logic [31:0] va;
		logic [31:0] mask;
		logic        more;
		posted = 0;
		va     = piece_va();
		if (walk_phase == PH_IDLE) begin
			if (it.opcode == OP_READ || it.opcode == OP_WRITE) begin
				// Out-of-range sizes are clamped to one or four bytes.
				sz = it.access_size;
				if (sz == 3'd0)
					sz = 3'd1;
				if (sz > 3'd4)
					sz = 3'd4;
				end_va     = it.virt_addr + {29'd0, sz} - 32'd1;
				walk_va    = it.virt_addr;
				walk_size  = sz;
				walk_byte  = 3'd0;
				walk_wr    = (it.opcode == OP_WRITE);
				walk_wdata = it.write_data;
				walk_rdata = 32'd0;
				walk_split = (it.virt_addr[31:12] != end_va[31:12]);
				start_piece();
			end
		end else if (it.opcode == OP_DATA) begin
			case (walk_phase)
				PH_DIR: begin
					if (!it.mem_data[0]) begin
						raise_fault();
					end else begin
						post_result(KIND_RD, {it.mem_data[31:12], va[21:12], 2'b00}, 3'd4,
							32'd0, 1'b0);
						walk_phase = PH_TBL;
					end
				end
				PH_TBL: begin
					if (!it.mem_data[0]) begin
						raise_fault();
					end else begin
						finish_piece({it.mem_data[31:12], va[11:0]}, more);
						if (more)
							start_piece();
					end
				end
				PH_DATA: begin
					if (walk_split) begin
						walk_rdata |= {24'd0, it.mem_data[7:0]} << {walk_byte[1:0], 3'b000};
					end else begin
						mask = (walk_size >= 3'd4) ? 32'hFFFF_FFFF
								: ((32'd1 << {walk_size, 3'b000}) - 32'd1);
						walk_rdata = it.mem_data & mask;
					end
					if (piece_is_last()) begin
						post_result(KIND_CMP, 32'd0, walk_size, walk_rdata, 1'b1);
						walk_phase = PH_IDLE;
					end else begin
						walk_byte++;
						start_piece();
					end
				end
				PH_DRAIN: begin
					start_piece();
				end
				default: begin
					walk_phase = PH_IDLE;
				end
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus store. The initial block below fills it one phase at a
	// time; the driver empties it.
	// ------------------------------------------------------------------
	item_t stim_q[$];
	int    phase_items;

	task automatic push_item(input logic [1:0] op, input logic [31:0] va, input logic [2:0] sz,
			input logic [31:0] wd, input logic [31:0] md);
		item_t it;
		it.opcode      = op;
		it.virt_addr   = va;
		it.access_size = sz;
		it.write_data  = wd;
		it.mem_data    = md;
		stim_q.push_back(it);
		phase_items++;
	endtask

	// A memory data item; the request fields are don't-care and get random values.
	task automatic push_mem(input logic [31:0] md);
		push_item(OP_DATA, $urandom, 3'($urandom_range(0, 7)), $urandom, md);
	endtask

	// Queues one request followed by the data items that carry it to its end.
	// Each directory or table entry is made non-present with the given percent
	// chance, and the request is abandoned there, as the block does.
	task automatic queue_access(input logic [1:0] op, input logic [31:0] va,
			input logic [2:0] raw_sz, input logic paged, input int fault_pct);
		int          sz;
		int          units;
		logic [31:0] end_va;
		logic [31:0] md;
		logic        split;
		logic        broken;
		sz     = (raw_sz == 3'd0) ? 1 : ((raw_sz > 3'd4) ? 4 : int'(raw_sz));
		end_va = va + sz - 1;
		split  = (va[31:12] != end_va[31:12]);
		units  = split ? sz : 1;
		broken = 1'b0;
		push_item(op, va, raw_sz, $urandom, $urandom);
		// An unpaged split write puts out two bytes per item and waits for a data
		// item to release each further pair.
		if (!paged && op == OP_WRITE && split) begin
			for (int k = 1; k < (sz + 1) / 2; k++)
				push_mem($urandom);
		end
		for (int u = 0; u < units && !broken; u++) begin
			if (paged) begin
				for (int lvl = 0; lvl < 2 && !broken; lvl++) begin
					md    = $urandom;
					md[0] = ($urandom_range(0, 99) >= fault_pct);
					broken = !md[0];
					push_mem(md);
				end
			end
			if (!broken && op == OP_READ)
				push_mem($urandom);
		end
	endtask

	// Registers are only written while the walk is idle and nothing is in flight.
	task automatic program_regs(input logic pg, input logic [19:0] dbf);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PAGING;
		cfg_data  <= {19'd0, pg};
		paging_on  = pg;
		@(posedge clk);
		cfg_index <= CFG_DIR_BASE;
		cfg_data  <= dbf;
		dir_frame  = dbf;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Closes a phase: finishes any walk left open by broken sequences, waits
	// for every owed result, then lets the block go quiet.
	task automatic settle_phase();
		logic [31:0] md;
		for (int k = 0; k < FLUSH_ITEMS; k++) begin
			md    = $urandom;
			md[0] = 1'b1;
			push_mem(md);
		end
		while (stim_q.size() != 0 || req.valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Translation off: whole and split accesses, size clamping, ignored items.
	task automatic directed_flat();
		push_item(OP_READ, 32'h0000_0000, 3'd4, 32'h0000_0000, 32'h0000_0000);
		push_mem(32'hFFFF_FFFF);
		push_item(OP_WRITE, 32'hFFFF_FFFF, 3'd1, 32'hFFFF_FFFF, 32'h0000_0000);
		// Split write of four bytes: two go out at once, the rest after one data item.
		push_item(OP_WRITE, 32'h0000_0FFE, 3'd4, 32'h8899_AABB, 32'h0000_0000);
		push_mem(32'h0000_0000);
		// Split read that wraps around the top of the address space.
		push_item(OP_READ, 32'hFFFF_FFFE, 3'd3, 32'h0000_0000, 32'h0000_0000);
		push_mem(32'h1234_56A1);
		push_mem(32'h0000_00B2);
		push_mem(32'hFFFF_FFC3);
		push_item(OP_READ, 32'h0000_0100, 3'd0, 32'h0000_0000, 32'h0000_0000);
		push_mem(32'hDEAD_BEEF);
		push_item(OP_WRITE, 32'h0000_0200, 3'd7, 32'hCAFE_F00D, 32'h0000_0000);
		// Data with no walk open is dropped.
		push_mem(32'h5555_5555);
		// A read is open while a second request and the unused opcode arrive.
		push_item(OP_READ, 32'h0000_0300, 3'd2, 32'h0000_0000, 32'h0000_0000);
		push_item(OP_WRITE, 32'h0000_0400, 3'd4, 32'h7777_7777, 32'h0000_0000);
		push_item(OP_UNUSED, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_mem(32'hAAAA_1234);
	endtask

	// Translation on with the highest directory frame: a clean walk, a missing
	// directory entry, and a split write whose second table entry is missing,
	// so the first byte stays written before the fault.
	task automatic directed_paged();
		push_item(OP_READ, 32'h1234_5678, 3'd2, 32'h0000_0000, 32'h0000_0000);
		push_mem(32'hFFFF_F001);
		push_mem(32'h0000_0001);
		push_mem(32'hFFFF_FFFF);
		push_item(OP_READ, 32'hFFC0_0000, 3'd4, 32'h0000_0000, 32'h0000_0000);
		push_mem(32'hFFFF_FFFE);
		push_item(OP_WRITE, 32'h0000_1FFF, 3'd2, 32'h0000_A55A, 32'h0000_0000);
		push_mem(32'h0001_2003);
		push_mem(32'h0003_4005);
		push_mem(32'h0005_6007);
		push_mem(32'h0007_8FFE);
	endtask

	// Mostly complete requests with random content; the rest is noise that opens
	// walks nobody finishes, hits a busy walk, or uses the unused opcode.
	task automatic random_phase(input int count);
		logic [31:0] va;
		logic [2:0]  sz;
		phase_items = 0;
		while (phase_items < count) begin
			if ($urandom_range(0, 99) < 85) begin
				if ($urandom_range(0, 3) == 0)
					va = {20'($urandom_range(0, 20'hFFFFF)),
						12'hFFF - 12'($urandom_range(0, 2))};
				else
					va = $urandom;
				if ($urandom_range(0, 9) == 0)
					sz = 3'($urandom_range(0, 7));
				else
					sz = 3'($urandom_range(1, 4));
				queue_access(2'($urandom_range(0, 1)), va, sz, paging_on, 8);
			end else begin
				push_item(2'($urandom_range(0, 3)), $urandom, 3'($urandom_range(0, 7)),
					$urandom, $urandom);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Driver. It sends in bursts of random length with random gaps, and
	// hands every accepted item to the predictor at the edge it is taken.
	// ------------------------------------------------------------------
	item_t on_wire;
	int    burst_left;
	int    gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid       <= 1'b0;
			req.opcode      <= OP_READ;
			req.virt_addr   <= 32'd0;
			req.access_size <= 3'd0;
			req.write_data  <= 32'd0;
			req.mem_data    <= 32'd0;
			burst_left       = 0;
			gap_left         = 0;
		end else begin
			if (req.valid && req.ready)
				translate_item(on_wire);
			if (!req.valid || req.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					req.valid <= 1'b0;
				end else if (stim_q.size() != 0) begin
					on_wire          = stim_q.pop_front();
					req.valid       <= 1'b1;
					req.opcode      <= on_wire.opcode;
					req.virt_addr   <= on_wire.virt_addr;
					req.access_size <= on_wire.access_size;
					req.write_data  <= on_wire.write_data;
					req.mem_data    <= on_wire.mem_data;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// A quarter of the bursts run straight into the next one.
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor. Ready follows a rotating 16-bit pattern that is
	// redrawn whenever its age runs out: always ready, random, or sparse.
	// Every accepted result is matched against the oldest owed result.
	// ------------------------------------------------------------------
	logic [15:0] ready_pat;
	int          pat_age;
	res_t        owed;

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			ready_pat  = 16'hFFFF;
			pat_age    = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual kind %0d addr 0x%0h",
						$time, rsp.kind, rsp.phys_addr);
				end else begin
					owed = awaited_results.pop_front();
					check_field("kind", {30'd0, owed.kind}, {30'd0, rsp.kind});
					check_field("phys_addr", owed.phys_addr, rsp.phys_addr);
					check_field("mem_size", {29'd0, owed.mem_size}, {29'd0, rsp.mem_size});
					check_field("result_data", owed.result_data, rsp.result_data);
					check_field("last", {31'd0, owed.last}, {31'd0, rsp.last});
				end
			end
			if (pat_age == 0) begin
				pat_age = $urandom_range(32, 96);
				case ($urandom_range(0, 2))
					0:       ready_pat = 16'hFFFF;
					1:       ready_pat = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
					default: ready_pat = 16'd1 << $urandom_range(0, 15);
				endcase
			end else begin
				pat_age--;
			end
			rsp.ready <= ready_pat[0];
			ready_pat  = {ready_pat[0], ready_pat[15:1]};
		end
	end

	// Hang detection: any handshake on either channel restarts the count.
	int hang_count = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				hang_count = 0;
			else
				hang_count++;
			if (hang_count >= HANG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence. Every phase starts from an idle block with fresh
	// register values; the extremes of both registers are visited.
	// The request and result channels get their reset values from the
	// driver and the monitor while arst_n is low.
	// ------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_PAGING;
		cfg_data        = 20'd0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		program_regs(1'b0, 20'hABCDE);
		directed_flat();
		settle_phase();

		program_regs(1'b1, 20'hFFFFF);
		directed_paged();
		settle_phase();

		program_regs(1'b1, 20'h00000);
		random_phase(75);
		settle_phase();

		program_regs(1'b0, 20'hFFFFF);
		random_phase(75);
		settle_phase();

		program_regs(1'b1, 20'($urandom_range(0, 20'hFFFFF)));
		random_phase(75);
		settle_phase();

		program_regs(1'b1, 20'hFFFFF);
		random_phase(75);
		settle_phase();

		program_regs(1'b0, 20'h00000);
		random_phase(75);
		settle_phase();

		program_regs(1'b1, 20'($urandom_range(0, 20'hFFFFF)));
		random_phase(75);
		settle_phase();

		// Anything still owed at this point was never delivered.
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
